// File: sv/dtlr_pkg.sv
package dtlr_pkg;

	localparam int WIDTH_DEF      = 64;
	localparam int HEIGHT_DEF     = 64;
	localparam int DEPTH_BITS_DEF = 32;

	// coordinate and Q16.16 depth widths of a line command
	localparam int CW = 6;
	localparam int ZW = 32;
	// the reciprocal numerator is 2^RECIP_SHIFT
	localparam int RECIP_SHIFT = 40;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV_A,
		ST_DIV_B,
		ST_DIV_D,
		ST_RD,
		ST_CMP
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: sv/dtlr_div.sv
module dtlr_div #(
	parameter int NW = 41,
	parameter int MW = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [NW-1:0]         dividend,
	input  logic [MW-1:0]         divisor,
	output logic [NW-1:0]         quo,
	output logic [MW-1:0]         rem,
	output dtlr_pkg::div_stat_t   stat
);

	localparam int KW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [MW-1:0] rem_q;
	logic [KW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [MW:0]   sh;
	logic [MW:0]   diff;
	logic          take;

	// one restoring step per cycle, most significant bit first
	assign sh   = {rem_q, quo_q[NW-1]};
	assign diff = sh - {1'b0, divisor};
	assign take = (sh >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= KW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == KW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], take};
			rem_q <= take ? diff[MW-1:0] : sh[MW-1:0];
		end
	end

	assign quo       = quo_q;
	assign rem       = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");

	a_start_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy_q) |=> (busy_q && cnt_q == KW'(NW)))
		else $error("divider failed to start");

	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q != KW'(1)) |=> !done_q)
		else $error("divider finished early");

endmodule

// File: sv/dtlr_zmem.sv
module dtlr_zmem #(
	parameter int DEPTH = 4096,
	parameter int DW    = 32
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [$clog2(DEPTH)-1:0]  waddr,
	input  logic signed [DW-1:0]      wdata,
	input  logic [$clog2(DEPTH)-1:0]  raddr,
	output logic signed [DW-1:0]      rdata
);

	logic signed [DW-1:0] mem [DEPTH];
	logic signed [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/depth_tested_line_raster.sv
// A draw word runs three divisions on the shared restoring divider, each over 41 quotient
// bits (a point skips the slope division), then per pixel a depth read state and a compare
// and write state, for 1 to 64 pixels, plus output stalls.
// A clear word sweeps the whole store, one store entry a cycle; no new word meanwhile.
// Reset: asynchronous, active low; the depth store is then swept to the far value
// before the first word is accepted.
module depth_tested_line_raster #(
	parameter int WIDTH      = dtlr_pkg::WIDTH_DEF,
	parameter int HEIGHT     = dtlr_pkg::HEIGHT_DEF,
	parameter int DEPTH_BITS = dtlr_pkg::DEPTH_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// x_start[5:0], y_start[11:6], depth_start[43:12], x_end[49:44],
	// y_end[55:50], depth_end[87:56], line_color[111:88]
	input  logic [111:0] s_tdata,
	// opcode
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pixel_x[5:0], pixel_y[11:6], pixel_color[35:12], zero[39:36]
	output logic [39:0]  m_tdata,
	// write_enable
	output logic         m_tuser,
	// last_pixel
	output logic         m_tlast
);

	localparam int CW    = dtlr_pkg::CW;
	localparam int ZW    = dtlr_pkg::ZW;
	localparam int DW    = DEPTH_BITS;
	localparam int NPIX  = WIDTH * HEIGHT;
	localparam int AW    = $clog2(NPIX);
	localparam int NW    = (DW + 1 > dtlr_pkg::RECIP_SHIFT + 1) ? DW + 1
		: dtlr_pkg::RECIP_SHIFT + 1;
	localparam int MW    = ZW;
	localparam int SW    = NW + 1;
	localparam int QW    = NW + 2;

	localparam logic signed [SW-1:0] HI = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [SW-1:0] LO = ~HI;
	localparam logic signed [DW-1:0] FAR = {1'b0, {(DW-1){1'b1}}};

	dtlr_pkg::state_t state_q, state_d;

	// command registers, endpoints already in walk order
	logic [CW-1:0]        xa_q, ya_q;
	logic signed [ZW-1:0] da_q, db_q;
	logic [23:0]          color_q;
	logic signed [CW:0]   ex_q, ey_q;
	logic [CW-1:0]        n_q, i_q;
	logic signed [DW-1:0] ra_q, rb_q;
	logic signed [NW:0]   qd_q;
	logic [CW-1:0]        rd_q;
	logic signed [DW-1:0] zq_q;
	logic [CW-1:0]        zr_q;
	logic signed [8:0]    rx_q, ry_q;
	logic signed [CW:0]   qx_q, qy_q;
	logic [AW-1:0]        clr_q;
	logic                 issued_q;

	logic                 m_tvalid_q, we_q, last_q;
	logic [CW-1:0]        ox_q, oy_q;
	logic [23:0]          ocolor_q;

	// accept-side decode
	logic [CW-1:0]        in_xs, in_ys, in_xe, in_ye;
	logic signed [ZW-1:0] in_ds, in_de;
	logic                 in_swap;
	logic [CW-1:0]        sw_xa, sw_ya, sw_xb, sw_yb;
	logic signed [CW:0]   in_ex, in_ey, in_aey;
	logic                 accept;

	assign in_xs   = s_tdata[5:0];
	assign in_ys   = s_tdata[11:6];
	assign in_ds   = s_tdata[43:12];
	assign in_xe   = s_tdata[49:44];
	assign in_ye   = s_tdata[55:50];
	assign in_de   = s_tdata[87:56];
	assign in_swap = (in_xe < in_xs) || ((in_xe == in_xs) && (in_ye < in_ys));
	assign sw_xa   = in_swap ? in_xe : in_xs;
	assign sw_ya   = in_swap ? in_ye : in_ys;
	assign sw_xb   = in_swap ? in_xs : in_xe;
	assign sw_yb   = in_swap ? in_ys : in_ye;
	assign in_ex   = $signed({1'b0, sw_xb}) - $signed({1'b0, sw_xa});
	assign in_ey   = $signed({1'b0, sw_yb}) - $signed({1'b0, sw_ya});
	assign in_aey  = in_ey[CW] ? -in_ey : in_ey;
	assign accept  = s_tvalid && s_tready;

	// shared divider
	logic                 div_start;
	logic [NW-1:0]        div_dividend, div_quo;
	logic [MW-1:0]        div_divisor, div_rem;
	dtlr_pkg::div_stat_t  div_stat;

	logic signed [ZW-1:0] dsel;
	logic [ZW:0]          dmag;
	logic signed [DW:0]   dslope;
	logic [DW:0]          dslope_mag;
	logic signed [SW-1:0] rsig;
	logic signed [DW-1:0] rsat;

	assign dsel       = (state_q == dtlr_pkg::ST_DIV_A) ? da_q : db_q;
	assign dmag       = dsel[ZW-1] ? -{dsel[ZW-1], dsel} : {dsel[ZW-1], dsel};
	assign dslope     = {rb_q[DW-1], rb_q} - {ra_q[DW-1], ra_q};
	assign dslope_mag = dslope[DW] ? -dslope : dslope;

	always_comb begin
		div_dividend = NW'(1) << dtlr_pkg::RECIP_SHIFT;
		div_divisor  = dmag[MW-1:0];
		if (state_q == dtlr_pkg::ST_DIV_D) begin
			div_dividend = NW'(dslope_mag);
			div_divisor  = MW'(n_q);
		end
	end

	// signed, saturated reciprocal from the unsigned quotient
	always_comb begin
		rsig = dsel[ZW-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
		if (dsel == '0)
			rsat = FAR;
		else if (rsig > HI)
			rsat = HI[DW-1:0];
		else if (rsig < LO)
			rsat = LO[DW-1:0];
		else
			rsat = rsig[DW-1:0];
	end

	dtlr_div #(.NW(NW), .MW(MW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quo      (div_quo),
		.rem      (div_rem),
		.stat     (div_stat)
	);

	// floor division of the depth slope by n
	logic signed [NW:0] qd_c;
	logic [CW-1:0]      rd_c;
	always_comb begin
		qd_c = $signed({1'b0, div_quo});
		rd_c = div_rem[CW-1:0];
		if (dslope[DW]) begin
			qd_c = -$signed({1'b0, div_quo});
			if (div_rem[CW-1:0] != '0) begin
				qd_c = qd_c - 1'b1;
				rd_c = n_q - div_rem[CW-1:0];
			end
		end
	end

	// current pixel
	logic [CW-1:0]        px, py;
	logic                 inr;
	logic [AW-1:0]        paddr;
	logic signed [DW-1:0] rcur;
	logic signed [DW-1:0] zrd;
	logic                 we_c;
	logic                 last_c;
	logic                 out_free;

	assign px       = xa_q + qx_q[CW-1:0];
	assign py       = ya_q + qy_q[CW-1:0];
	assign inr      = ({1'b0, px} < (CW+1)'(WIDTH)) && ({1'b0, py} < (CW+1)'(HEIGHT));
	assign paddr    = AW'(32'(py) * WIDTH + 32'(px));
	assign rcur     = zq_q + DW'((zq_q[DW-1] && zr_q != '0) ? 1 : 0);
	assign we_c     = inr && (rcur < zrd);
	assign last_c   = (i_q == n_q);
	assign out_free = !m_tvalid_q || m_tready;

	// depth store write port
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic signed [DW-1:0] mem_wdata;

	dtlr_zmem #(.DEPTH(NPIX), .DW(DW)) u_zmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (paddr),
		.rdata (zrd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dtlr_pkg::ST_CLEAR: if (clr_q == AW'(NPIX - 1)) state_d = dtlr_pkg::ST_IDLE;
			dtlr_pkg::ST_IDLE: begin
				if (s_tvalid)
					state_d = s_tuser ? dtlr_pkg::ST_CLEAR : dtlr_pkg::ST_DIV_A;
			end
			dtlr_pkg::ST_DIV_A: if (div_stat.done) state_d = dtlr_pkg::ST_DIV_B;
			dtlr_pkg::ST_DIV_B: begin
				if (div_stat.done)
					state_d = (n_q == '0) ? dtlr_pkg::ST_RD : dtlr_pkg::ST_DIV_D;
			end
			dtlr_pkg::ST_DIV_D: if (div_stat.done) state_d = dtlr_pkg::ST_RD;
			dtlr_pkg::ST_RD:    state_d = dtlr_pkg::ST_CMP;
			dtlr_pkg::ST_CMP: begin
				if (out_free)
					state_d = last_c ? dtlr_pkg::ST_IDLE : dtlr_pkg::ST_RD;
			end
			default: state_d = dtlr_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = paddr;
		mem_wdata = rcur;
		case (state_q)
			dtlr_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = FAR;
			end
			dtlr_pkg::ST_IDLE: s_tready = 1'b1;
			dtlr_pkg::ST_DIV_A, dtlr_pkg::ST_DIV_B, dtlr_pkg::ST_DIV_D:
				div_start = !issued_q;
			dtlr_pkg::ST_CMP: mem_we = out_free && we_c;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dtlr_pkg::ST_CLEAR;
			clr_q      <= '0;
			issued_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dtlr_pkg::ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			else if (accept)
				clr_q <= '0;
			if (div_start)
				issued_q <= 1'b1;
			else if (div_stat.done)
				issued_q <= 1'b0;
			if (state_q == dtlr_pkg::ST_CMP && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// datapath registers
	logic signed [8:0]  tx, ty, two_n;
	logic signed [QW-1:0] zsum;
	logic [CW:0]          rsum;
	assign two_n = $signed({2'b00, n_q, 1'b0});
	assign tx    = rx_q + $signed({ex_q[CW], ex_q, 1'b0});
	assign ty    = ry_q + $signed({ey_q[CW], ey_q, 1'b0});
	assign rsum  = {1'b0, zr_q} + {1'b0, rd_q};
	assign zsum  = QW'(zq_q) + QW'(qd_q) + QW'((rsum >= {1'b0, n_q}) ? 1 : 0);

	always_ff @(posedge clk) begin
		if (accept) begin
			xa_q    <= sw_xa;
			ya_q    <= sw_ya;
			da_q    <= in_swap ? in_de : in_ds;
			db_q    <= in_swap ? in_ds : in_de;
			color_q <= s_tdata[111:88];
			ex_q    <= in_ex;
			ey_q    <= in_ey;
			n_q     <= (in_ex > in_aey) ? in_ex[CW-1:0] : in_aey[CW-1:0];
		end
		if (div_stat.done && state_q == dtlr_pkg::ST_DIV_A)
			ra_q <= rsat;
		if (div_stat.done && state_q == dtlr_pkg::ST_DIV_D) begin
			qd_q <= qd_c;
			rd_q <= rd_c;
		end
		// start the walk at the first endpoint
		if (div_stat.done && state_q == dtlr_pkg::ST_DIV_B) begin
			rb_q <= rsat;
			zq_q <= ra_q;
			zr_q <= '0;
			rx_q <= $signed({3'b000, n_q});
			ry_q <= $signed({3'b000, n_q});
			qx_q <= '0;
			qy_q <= '0;
			i_q  <= '0;
		end
		if (state_q == dtlr_pkg::ST_CMP && out_free) begin
			ox_q     <= px;
			oy_q     <= py;
			ocolor_q <= color_q;
			we_q     <= we_c;
			last_q   <= last_c;
			// advance to the next step
			i_q  <= i_q + 1'b1;
			zq_q <= zsum[DW-1:0];
			zr_q <= (rsum >= {1'b0, n_q}) ? CW'(rsum - {1'b0, n_q}) : rsum[CW-1:0];
			if (tx >= two_n) begin
				rx_q <= tx - two_n;
				qx_q <= qx_q + 1'b1;
			end else if (tx < 0) begin
				rx_q <= tx + two_n;
				qx_q <= qx_q - 1'b1;
			end else begin
				rx_q <= tx;
			end
			if (ty >= two_n) begin
				ry_q <= ty - two_n;
				qy_q <= qy_q + 1'b1;
			end else if (ty < 0) begin
				ry_q <= ty + two_n;
				qy_q <= qy_q - 1'b1;
			end else begin
				ry_q <= ty;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, ocolor_q, oy_q, ox_q};
	assign m_tuser  = we_q;
	assign m_tlast  = last_q;

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dtlr_pkg::ST_CLEAR) |-> !s_tready)
		else $error("word accepted during depth clear");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dtlr_pkg::ST_RD || state_q == dtlr_pkg::ST_CMP) |-> (i_q <= n_q))
		else $error("walk ran past the far endpoint");

	a_store_write_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dtlr_pkg::ST_CMP && mem_we) |=> (m_tvalid_q && we_q))
		else $error("depth written without a passing fragment");

	a_last_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dtlr_pkg::ST_CMP && out_free && last_c) |=>
		(state_q == dtlr_pkg::ST_IDLE && m_tlast))
		else $error("last pixel not flagged at end of line");

endmodule

// File: test/depth_tested_line_raster_tb.sv
`timescale 1ns / 1ps

module depth_tested_line_raster_tb;

	localparam int GRID_W = 64;
	localparam int GRID_H = 64;
	localparam logic OP_DRAW  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;
	localparam longint FAR_DEPTH = 64'sd2147483647;
	localparam longint NEAR_LIMIT = -64'sd2147483648;

	typedef struct packed {
		logic       last;
		logic       we;
		logic [23:0] color;
		logic [5:0] py;
		logic [5:0] px;
	} fragment_t;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [111:0]  s_tdata;
	logic          s_tuser;
	logic          m_tvalid;
	logic          m_tready;
	logic [39:0]   m_tdata;
	logic          m_tuser;
	logic          m_tlast;

	longint    zbuf [GRID_W*GRID_H];
	fragment_t pending_frags [$];
	int        error_count;
	bit        src_idle_en;
	bit        sink_idle_en;
	int        sink_hold;

	depth_tested_line_raster u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint recip_of(logic signed [31:0] d);
		longint q;
		if (d == 0)
			return FAR_DEPTH;
		q = (64'sd1 <<< 40) / longint'(d);
		if (q > FAR_DEPTH) q = FAR_DEPTH;
		if (q < NEAR_LIMIT) q = NEAR_LIMIT;
		return q;
	endfunction

	function automatic void far_fill();
		foreach (zbuf[k])
			zbuf[k] = FAR_DEPTH;
	endfunction

	// rasterize one draw word into expected fragments, updating the depth copy
	function automatic void raster_line(logic [5:0] x0, logic [5:0] y0, logic [31:0] z0,
			logic [5:0] x1, logic [5:0] y1, logic [31:0] z1, logic [23:0] col);
		longint xa, ya, xb, yb, ra, rb, t, dx, dy, n, px, py, r;
		fragment_t f;
		xa = longint'(x0); ya = longint'(y0); xb = longint'(x1); yb = longint'(y1);
		ra = recip_of(z0); rb = recip_of(z1);
		if (xb < xa || (xb == xa && yb < ya)) begin
			t = xa; xa = xb; xb = t;
			t = ya; ya = yb; yb = t;
			t = ra; ra = rb; rb = t;
		end
		dx = (xb > xa) ? xb - xa : xa - xb;
		dy = (yb > ya) ? yb - ya : ya - yb;
		n = (dx > dy) ? dx : dy;
		for (longint i = 0; i <= n; i++) begin
			if (n == 0) begin
				px = xa; py = ya; r = ra;
			end else begin
				px = (2*(xa*(n-i) + xb*i) + n) / (2*n);
				py = (2*(ya*(n-i) + yb*i) + n) / (2*n);
				r = (ra*(n-i) + rb*i) / n;
			end
			f.we = 1'b0;
			if (r < zbuf[py*GRID_W + px]) begin
				zbuf[py*GRID_W + px] = r;
				f.we = 1'b1;
			end
			f.px = px[5:0];
			f.py = py[5:0];
			f.color = col;
			f.last = (i == n);
			pending_frags.push_back(f);
		end
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
		error_count++;
	endtask

	task automatic send_word(logic op, logic [5:0] x0, logic [5:0] y0, logic [31:0] z0,
			logic [5:0] x1, logic [5:0] y1, logic [31:0] z1, logic [23:0] col);
		while (src_idle_en && $urandom_range(99) < 37) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {col, z1, y1, x1, z0, y0, x0};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (op == OP_CLEAR)
			far_fill();
		else
			raster_line(x0, y0, z0, x1, y1, z1, col);
	endtask

	task automatic send_random_line(bit short_line);
		logic [5:0] x0, y0, x1, y1;
		logic [31:0] z0, z1;
		x0 = 6'($urandom); y0 = 6'($urandom);
		if (short_line) begin
			x1 = 6'(x0 + $urandom_range(7) - 3);
			y1 = 6'(y0 + $urandom_range(7) - 3);
		end else begin
			x1 = 6'($urandom); y1 = 6'($urandom);
		end
		case ($urandom_range(3))
			0: begin z0 = $urandom; z1 = $urandom; end
			1: begin z0 = $urandom_range(32'h0008_0000, 32'h0001_0000);
				z1 = $urandom_range(32'h0008_0000, 32'h0001_0000); end
			2: begin z0 = -$urandom_range(32'h0004_0000, 1); z1 = $urandom_range(255); end
			default: begin z0 = $urandom_range(32'h0100_0000, 32'h0000_4000);
				z1 = z0 + $urandom_range(32'h0001_0000); end
		endcase
		send_word(OP_DRAW, x0, y0, z0, x1, y1, z1, 24'($urandom));
	endtask

	// drop the input and wait until every expected word has been seen
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_frags.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_word(OP_DRAW, 6'd0, 6'd0, 32'h0001_0000, 6'd63, 6'd63, 32'h7FFF_FFFF, 24'hFFFFFF);
		send_word(OP_DRAW, 6'd63, 6'd0, 32'h8000_0000, 6'd0, 6'd63, 32'hFFFF_FFFF, 24'h000000);
		send_word(OP_DRAW, 6'd10, 6'd10, 32'h0000_0001, 6'd10, 6'd10, 32'h0002_0000, 24'h123456);
		send_word(OP_DRAW, 6'd10, 6'd10, 32'h0000_0000, 6'd10, 6'd10, 32'h0000_0000, 24'hABCDEF);
		send_word(OP_DRAW, 6'd5, 6'd40, 32'h0002_0000, 6'd5, 6'd3, 32'h0004_0000, 24'h00FF00);
		send_word(OP_DRAW, 6'd60, 6'd7, 32'h0003_0000, 6'd2, 6'd7, 32'h0000_8000, 24'hFF0000);
		send_word(OP_DRAW, 6'd0, 6'd0, 32'h0001_0000, 6'd63, 6'd63, 32'h0001_0000, 24'h0000FF);
		send_word(OP_DRAW, 6'd1, 6'd2, 32'hFFFF_0000, 6'd40, 6'd20, 32'h0000_0000, 24'h555555);
		send_word(OP_DRAW, 6'd3, 6'd60, 32'h0010_0000, 6'd20, 6'd1, 32'h0010_0000, 24'hAAAAAA);
		send_word(OP_CLEAR, 6'h3F, 6'h3F, 32'hFFFF_FFFF, 6'h3F, 6'h3F, 32'hFFFF_FFFF, 24'hFFFFFF);
		send_word(OP_DRAW, 6'd0, 6'd0, 32'h0001_0000, 6'd63, 6'd63, 32'h7FFF_FFFF, 24'h0F0F0F);
		send_word(OP_DRAW, 6'd63, 6'd63, 32'h0000_0100, 6'd63, 6'd63, 32'h0000_0100, 24'hF0F0F0);
		wait_drained();
	endtask

	task automatic test_random_lines(int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(29) == 0)
				send_word(OP_CLEAR, 6'($urandom), 6'($urandom), $urandom, 6'($urandom),
					6'($urandom), $urandom, 24'($urandom));
			else
				send_random_line($urandom_range(2) != 0);
		end
		wait_drained();
	endtask

	// sink stalls for a long stretch while short lines keep coming
	task automatic test_backpressure();
		sink_hold = 400;
		for (int k = 0; k < 20; k++)
			send_random_line(1'b1);
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_frags.size() == 0) begin
				report_mismatch("unexpected word", longint'(m_tdata), 0);
			end else begin
				fragment_t want;
				want = pending_frags.pop_front();
				if (m_tdata[5:0] !== want.px)
					report_mismatch("pixel_x", longint'(m_tdata[5:0]), longint'(want.px));
				if (m_tdata[11:6] !== want.py)
					report_mismatch("pixel_y", longint'(m_tdata[11:6]), longint'(want.py));
				if (m_tdata[35:12] !== want.color)
					report_mismatch("pixel_color", longint'(m_tdata[35:12]),
						longint'(want.color));
				if (m_tuser !== want.we)
					report_mismatch("write_enable", longint'(m_tuser), longint'(want.we));
				if (m_tlast !== want.last)
					report_mismatch("last_pixel", longint'(m_tlast), longint'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(sink_idle_en && $urandom_range(99) < 37);
		end
	end

	initial begin
		#100_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		error_count = 0;
		sink_hold = 0;
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		far_fill();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_lines(60);
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
		test_random_lines(130);
		test_backpressure();
		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: filelist.f
sv/dtlr_pkg.sv
sv/dtlr_div.sv
sv/dtlr_zmem.sv
sv/depth_tested_line_raster.sv
test/depth_tested_line_raster_tb.sv
